// ----- rtl/opp_pkg.sv -----
// Shared types, sizes and controller codes for the OLED pixel plot engine.
// No dependencies; imported by opp_dp, opp_ctrl and the top level.
package opp_pkg;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;
  localparam int DEPTH   = COLUMNS * PAGES;
  localparam int AW      = $clog2(DEPTH);

  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_HI_CMD    = 8'h10;
  localparam logic [7:0] COL_HI_MASK   = 8'hF0;
  localparam logic [7:0] COL_LO_MASK   = 8'h0F;

  typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
    logic       set_pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COL_HI,
    S_COL_LO,
    S_DATA
  } state_e;

  typedef enum logic [1:0] {
    SEL_PAGE,
    SEL_COL_HI,
    SEL_COL_LO,
    SEL_DATA
  } byte_sel_e;

  typedef struct packed {
    logic      clr_en;
    logic      load_in;
    logic      out_load;
    byte_sel_e out_sel;
    logic      wr_en;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic in_range;
  } dp_status_t;

endpackage

// ----- rtl/opp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module opp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/opp_dp.sv -----
// Datapath: request capture, command byte formatting, frame store and output register.
// Depends on opp_pkg and opp_ram.
module opp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  opp_pkg::in_item_t  in_data_i,
  input  logic               out_stall_i,
  input  opp_pkg::dp_cmd_t   cmd_i,
  output opp_pkg::dp_status_t status_o,
  output logic               out_valid_o,
  output opp_pkg::out_item_t out_data_o
);
  import opp_pkg::*;

  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q, out_d;

  logic [7:0]    col_q;
  logic          set_q;
  logic [7:0]    mask_q;
  logic [AW-1:0] idx_q;
  logic          in_range_q;

  logic [4:0]    band;
  logic [7:0]    page_cmd;
  logic [AW-1:0] idx;
  logic          in_range;
  logic [7:0]    rd_data;
  logic [7:0]    new_byte;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  assign band     = in_data_i.row[7:3];
  assign page_cmd = 8'(PAGE_CMD_BASE + 8'(PAGES - 1) - {3'b000, band});
  assign idx      = AW'(AW'(in_data_i.column) * AW'(PAGES) + AW'(PAGES - 1) - AW'(band));
  assign in_range = ({1'b0, in_data_i.column} < 9'(COLUMNS))
                 && ({1'b0, in_data_i.row} < 9'(PAGES * 8));

  assign new_byte = set_q ? (rd_data | mask_q) : (rd_data & ~mask_q);

  // clearing pass owns the write port until it finishes
  assign ram_we    = cmd_i.clr_en | cmd_i.wr_en;
  assign ram_waddr = cmd_i.clr_en ? clr_cnt_q : idx_q;
  assign ram_wdata = cmd_i.clr_en ? 8'h00 : new_byte;

  opp_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load_in),
    .raddr_i (idx),
    .rdata_o (rd_data)
  );

  always_comb begin
    clr_cnt_d   = cmd_i.clr_en ? AW'(clr_cnt_q + 1'b1) : clr_cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      case (cmd_i.out_sel)
        SEL_PAGE:   out_d = '{out_byte: page_cmd, is_data: 1'b0, last: 1'b0};
        SEL_COL_HI: out_d = '{out_byte: ((col_q & COL_HI_MASK) >> 4) | COL_HI_CMD,
                              is_data: 1'b0, last: 1'b0};
        SEL_COL_LO: out_d = '{out_byte: col_q & COL_LO_MASK, is_data: 1'b0,
                              last: !in_range_q};
        SEL_DATA:   out_d = '{out_byte: new_byte, is_data: 1'b1, last: 1'b1};
        default:    out_d = out_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.load_in) begin
      col_q      <= in_data_i.column;
      set_q      <= in_data_i.set_pixel;
      mask_q     <= 8'h80 >> in_data_i.row[2:0];
      idx_q      <= idx;
      in_range_q <= in_range;
    end
  end

  assign status_o.clr_last = (clr_cnt_q == AW'(DEPTH - 1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.in_range = in_range_q;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// ----- rtl/opp_ctrl.sv -----
// Controller: clearing pass after reset, then one request walked through its output bytes.
// Depends on opp_pkg.
module opp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  opp_pkg::dp_status_t status_i,
  output opp_pkg::dp_cmd_t    cmd_o
);
  import opp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '{clr_en: 1'b0, load_in: 1'b0, out_load: 1'b0,
                   out_sel: SEL_PAGE, wr_en: 1'b0};
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = !status_i.out_free;
        // page command is loaded into the output register in the accept cycle, frame store read starts too
        if (in_valid_i && status_i.out_free) begin
          cmd_o.load_in  = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_PAGE;
          state_d        = S_COL_HI;
        end
      end
      S_COL_HI: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_COL_HI;
          state_d        = S_COL_LO;
        end
      end
      S_COL_LO: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_COL_LO;
          state_d        = status_i.in_range ? S_DATA : S_IDLE;
        end
      end
      S_DATA: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = SEL_DATA;
          cmd_o.wr_en    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/oled_pixel_plot_engine.sv -----
// Top level of the OLED pixel plot engine: controller plus datapath.
// Depends on opp_pkg, opp_ctrl, opp_dp (and opp_ram through opp_dp).
//
//   channel | direction | payload            | handshake
//   --------+-----------+--------------------+------------------------
//   in      | input     | in_item_t          | in_valid_i / in_stall_o
//   out     | output    | out_item_t         | out_valid_o / out_stall_i
//
// A request emits 4 bytes when it hits the display (3 command bytes plus the
// data byte) and 3 when out of range; the output register issues one byte per
// cycle while out_stall_i is low. After reset a clearing pass zeroes all
// COLUMNS*PAGES frame store bytes (1024 by default) one per cycle; in_stall_o is high.
// A stall on the output holds the current byte and pauses the sequencer.
module oled_pixel_plot_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  opp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output opp_pkg::out_item_t out_data_o
);
  import opp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  opp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  opp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- bench/oled_pixel_plot_engine_test.sv -----
// Self-checking testbench for oled_pixel_plot_engine: a directed table, then random
// pixel plots checked against a local frame store predictor. Depends on opp_pkg and the top level.
module oled_pixel_plot_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import opp_pkg::*;

  localparam int QUIET_LIMIT = 3000;  // covers the clearing pass after reset
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    in_item_t    stim;
    logic [2:0]  n_typed;  // 0: expected bytes come from the predictor
    logic [31:0] seq;      // typed bytes, first one in the top byte
  } plot_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  int hits_sent = 0;
  int bytes_checked = 0;

  logic [7:0] frame_bytes [DEPTH] = '{default: 8'h00};
  out_item_t  expected_bytes [$];

  plot_row_t directed_rows [22] = '{
    '{'{8'd0,   8'd0,   1'b1}, 3'd4, 32'hB7100080},
    '{'{8'd0,   8'd0,   1'b0}, 3'd4, 32'hB7100000},
    '{'{8'd127, 8'd63,  1'b1}, 3'd4, 32'hB0170F01},
    '{'{8'd127, 8'd63,  1'b0}, 3'd4, 32'hB0170F00},
    '{'{8'd127, 8'd0,   1'b0}, 3'd4, 32'hB7170F00},
    '{'{8'd15,  8'd7,   1'b1}, 3'd4, 32'hB7100F01},
    '{'{8'd16,  8'd0,   1'b1}, 3'd4, 32'hB7110080},
    '{'{8'd64,  8'd32,  1'b1}, 3'd4, 32'hB3140080},
    '{'{8'd10,  8'd63,  1'b1}, 3'd4, 32'hB0100A01},
    '{'{8'd10,  8'd62,  1'b1}, 3'd0, 32'h0},
    '{'{8'd10,  8'd56,  1'b1}, 3'd0, 32'h0},
    '{'{8'd3,   8'd8,   1'b1}, 3'd4, 32'hB6100380},
    '{'{8'd3,   8'd15,  1'b1}, 3'd0, 32'h0},
    '{'{8'd3,   8'd8,   1'b0}, 3'd0, 32'h0},
    '{'{8'd128, 8'd0,   1'b1}, 3'd3, 32'hB7180000},
    '{'{8'd255, 8'd255, 1'b1}, 3'd3, 32'h981F0F00},
    '{'{8'd0,   8'd64,  1'b1}, 3'd3, 32'hAF100000},
    '{'{8'd5,   8'd255, 1'b0}, 3'd3, 32'h98100500},
    '{'{8'd255, 8'd0,   1'b0}, 3'd3, 32'hB71F0F00},
    '{'{8'd127, 8'd64,  1'b1}, 3'd3, 32'hAF170F00},
    '{'{8'd128, 8'd63,  1'b1}, 3'd3, 32'hB0180000},
    '{'{8'd10,  8'd62,  1'b0}, 3'd0, 32'h0}
  };

  oled_pixel_plot_engine u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Plot one pixel into the local frame store and return the bytes it should emit.
  function automatic void plot_pixel(input in_item_t px, output out_item_t [3:0] res,
                                     output int n);
    int         band;
    int         idx;
    logic       hit;
    logic [7:0] mask;
    logic [7:0] v;
    band = int'(px.row) >> 3;
    hit  = (int'(px.column) < COLUMNS) && (int'(px.row) < PAGES * 8);
    res  = '0;
    res[0] = '{8'(int'(PAGE_CMD_BASE) + PAGES - 1 - band), 1'b0, 1'b0};
    res[1] = '{((px.column & COL_HI_MASK) >> 4) | COL_HI_CMD, 1'b0, 1'b0};
    res[2] = '{px.column & COL_LO_MASK, 1'b0, !hit};
    n = 3;
    if (hit) begin
      idx  = int'(px.column) * PAGES + (PAGES - 1 - band);
      mask = 8'h80 >> px.row[2:0];
      v    = px.set_pixel ? (frame_bytes[idx] | mask) : (frame_bytes[idx] & ~mask);
      frame_bytes[idx] = v;
      res[3] = '{v, 1'b1, 1'b1};
      n = 4;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    if (errors < 20) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Called just after a rising edge; returns at the edge where the transaction happens.
  task automatic send_pixel(input in_item_t px, input logic [2:0] n_typed,
                            input logic [31:0] seq);
    out_item_t [3:0] res;
    int              n;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk_i); while (in_stall);
    plot_pixel(px, res, n);
    items_sent++;
    if (n == 4) hits_sent++;
    if (n_typed != 0) begin
      for (int k = 0; k < n_typed; k++)
        expected_bytes.push_back('{seq[31 - 8 * k -: 8], k == 3, k == n_typed - 1});
    end else begin
      for (int k = 0; k < n; k++) expected_bytes.push_back(res[k]);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic in_item_t random_pixel();
    in_item_t px;
    int       r;
    r = $urandom_range(99);
    if (r < 40) begin
      // small hot region so bits of the same bytes get set and cleared repeatedly
      px.column = 8'($urandom_range(3));
      px.row    = 8'($urandom_range(15));
    end else if (r < 75) begin
      px.column = 8'($urandom_range(COLUMNS - 1));
      px.row    = 8'($urandom_range(PAGES * 8 - 1));
    end else begin
      px.column = 8'($urandom_range(255));
      px.row    = 8'($urandom_range(255));
    end
    px.set_pixel = 1'($urandom_range(1));
    return px;
  endfunction

  // Output monitor, stall generator and watchdog
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h", out_data.out_byte));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_data.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %02h, want %02h",
                                    out_data.out_byte, want.out_byte));
          if (out_data.is_data !== want.is_data)
            flag_mismatch($sformatf("is_data %b, want %b on byte %02h",
                                    out_data.is_data, want.is_data, want.out_byte));
          if (out_data.last !== want.last)
            flag_mismatch($sformatf("last %b, want %b on byte %02h",
                                    out_data.last, want.last, want.out_byte));
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    int idle_sched [5]  = '{0, 81, 0, 22, 0};
    int stall_sched [5] = '{0, 0, 81, 22, 0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_pixel(directed_rows[i].stim, directed_rows[i].n_typed, directed_rows[i].seq);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      idle_pct  = idle_sched[p];
      stall_pct = stall_sched[p];
      for (int i = 0; i < PHASE_ITEMS; i++) send_pixel(random_pixel(), 3'd0, 32'h0);
      // hold off new requests until every byte of this phase is out
      wait_drained();
    end

    $display("Sent %0d plot requests (%0d on screen), checked %0d output bytes",
             items_sent, hits_sent, bytes_checked);
    $display("Idle/stall mixes: none, sender 81%%, receiver 81%%, both 22%%, none");
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d bytes still outstanding", errors, expected_bytes.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
